// ----- design/sd_card_init_and_block_command_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// SD sequencer assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SD_CARD_INIT_AND_BLOCK_COMMAND_SEQUENCER_ASSERT_SVH
`define SD_CARD_INIT_AND_BLOCK_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked at every clock edge out of reset
`define SDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sdc_pkg.sv -----
// ----------------------------------------------------------------------------
// sdc_pkg
// Types, codes and constants of the SD card init and block command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

	localparam int POLL_COUNT_WIDTH = 20;
	localparam int POLL_LIMIT_W     = 20;
	localparam int ATTEMPTS_W       = 8;
	localparam int CFG_DATA_W       = 20;
	localparam int S_TDATA_W        = 96;
	localparam int S_TUSER_W        = 2;
	localparam int M_TDATA_W        = 128;

	localparam logic [POLL_LIMIT_W-1:0] POLL_LIMIT_RST = 20'd100000;
	localparam logic [ATTEMPTS_W-1:0]   ATTEMPTS_RST   = 8'd10;

	localparam logic CFG_POLL_LIMIT = 1'b0;
	localparam logic CFG_OP_COND    = 1'b1;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_POLL  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_GO_IDLE = 4'd1;
	localparam logic [3:0] PH_IF_COND = 4'd2;
	localparam logic [3:0] PH_APP     = 4'd3;
	localparam logic [3:0] PH_OP_COND = 4'd4;
	localparam logic [3:0] PH_CID     = 4'd5;
	localparam logic [3:0] PH_RCA     = 4'd6;
	localparam logic [3:0] PH_SELECT  = 4'd7;
	localparam logic [3:0] PH_CSD     = 4'd8;
	localparam logic [3:0] PH_XFER    = 4'd9;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_INIT_OK   = 3'd1;
	localparam logic [2:0] ST_INIT_FAIL = 3'd2;
	localparam logic [2:0] ST_XFER_OK   = 3'd3;
	localparam logic [2:0] ST_XFER_FAIL = 3'd4;
	localparam logic [2:0] ST_REJECT    = 3'd5;

	localparam logic [2:0] CAUSE_NONE      = 3'd0;
	localparam logic [2:0] CAUSE_TIMEOUT   = 3'd1;
	localparam logic [2:0] CAUSE_CRC       = 3'd2;
	localparam logic [2:0] CAUSE_NOINT     = 3'd3;
	localparam logic [2:0] CAUSE_EXHAUSTED = 3'd4;

	localparam int BIT_COMPLETE = 0;
	localparam int BIT_CRC      = 15;
	localparam int BIT_TIMEOUT  = 16;

	localparam logic [16:0] CLR_COMPLETE = 17'h00001;
	localparam logic [16:0] CLR_CRC      = 17'h08000;
	localparam logic [16:0] CLR_TIMEOUT  = 17'h10000;

	localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
	localparam logic [5:0] CMD_CID      = 6'd2;
	localparam logic [5:0] CMD_RCA      = 6'd3;
	localparam logic [5:0] CMD_SELECT   = 6'd7;
	localparam logic [5:0] CMD_IF_COND  = 6'd8;
	localparam logic [5:0] CMD_CSD      = 6'd9;
	localparam logic [5:0] CMD_READ     = 6'd17;
	localparam logic [5:0] CMD_WRITE    = 6'd24;
	localparam logic [5:0] CMD_OP_COND  = 6'd41;
	localparam logic [5:0] CMD_APP      = 6'd55;

	localparam logic [31:0] ARG_IF_COND = 32'h000001AA;
	localparam logic [31:0] ARG_OCR     = 32'h00300000;
	localparam logic [31:0] ARG_HCS     = 32'h40000000;
	localparam int          OCR_READY   = 31;

	typedef struct packed {
		logic [3:0]            phase;
		logic [ATTEMPTS_W-1:0] attempts_left;
		logic                  card_is_v2;
		logic [15:0]           rel_card_addr;
		logic [31:0]           op_cond_word;
	} seq_state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] irq_stat;
		logic [31:0] resp_word;
		logic [31:0] blk_num;
	} item_t;

	typedef struct packed {
		logic [31:0] ocr_out;
		logic        is_v2_card;
		logic [15:0] rca_out;
		logic [2:0]  fail_cause;
		logic [2:0]  seq_status;
		logic [16:0] clear_mask;
		logic [13:0] cmd_word;
		logic [31:0] cmd_arg;
		logic [5:0]  cmd_idx;
		logic        issue_cmd;
	} result_t;

	typedef struct packed {
		logic [POLL_LIMIT_W-1:0] poll_limit;
		logic [ATTEMPTS_W-1:0]   op_cond_attempts;
	} cfg_t;

endpackage

`default_nettype wire

// ----- design/sd_card_init_and_block_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// sd_card_init_and_block_command_sequencer
// SD host command sequencer: init walk, status polls, block read/write issue.
// ----------------------------------------------------------------------------
//
// channel  | dir | tdata / tuser
// ---------+-----+---------------------------------------------------------
// s_axis   | in  | tuser: op; tdata: irq_stat, resp_word, blk_num
// m_axis   | out | tdata: issue_cmd .. ocr_out, one result per item
// cfg      | in  | cfg_we, cfg_index, cfg_data; no read-back
//
// One item per cycle sustained while m_tready keeps up; an input transfer is
// held in the input register, then the step logic writes the result register,
// which waits while a stalled result is held.
// arst_n clears control and sequencer state and resets configuration at once.
// A stalled result holds; the input register still takes one item behind it.
//
`default_nettype none

module sd_card_init_and_block_command_sequencer #(
	parameter int POLL_COUNT_WIDTH = sdc_pkg::POLL_COUNT_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// s_axis
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [sdc_pkg::S_TDATA_W-1:0]  s_tdata,  // irq_stat, resp_word, blk_num
	input  wire logic [sdc_pkg::S_TUSER_W-1:0]  s_tuser,  // op
	// m_axis
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [sdc_pkg::M_TDATA_W-1:0]  m_tdata,  // issue_cmd, cmd_idx, cmd_arg,
	                                                      // cmd_word, clear_mask, seq_status,
	                                                      // fail_cause, rca_out, is_v2_card,
	                                                      // ocr_out, zero pad
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ResW = $bits(sdc_pkg::result_t);

	sdc_pkg::cfg_t               cfg;
	sdc_pkg::item_t              item_s1;
	logic                        valid_s1;
	sdc_pkg::seq_state_t         st_q;
	sdc_pkg::seq_state_t         st_next;
	logic [POLL_COUNT_WIDTH-1:0] poll_count_q;
	logic [POLL_COUNT_WIDTH-1:0] poll_count_next;
	sdc_pkg::result_t            res;
	sdc_pkg::result_t            res_q;
	logic                        out_valid_q;
	logic                        adv;

	sdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdc_step #(
		.POLL_COUNT_WIDTH (POLL_COUNT_WIDTH)
	) u_step (
		.item            (item_s1),
		.st              (st_q),
		.poll_count      (poll_count_q),
		.cfg             (cfg),
		.st_next         (st_next),
		.poll_count_next (poll_count_next),
		.res             (res)
	);

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op        <= s_tuser;
			item_s1.irq_stat  <= s_tdata[31:0];
			item_s1.resp_word <= s_tdata[63:32];
			item_s1.blk_num   <= s_tdata[95:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= '0;
			poll_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			st_q         <= st_next;
			poll_count_q <= poll_count_next;
			out_valid_q  <= 1'b1;
		end else if (m_tready) begin
			out_valid_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(sdc_pkg::M_TDATA_W - ResW){1'b0}}, res_q};

endmodule

`default_nettype wire

// ----- design/sdc_cfg.sv -----
// ----------------------------------------------------------------------------
// sdc_cfg
// Configuration registers: poll limit and op-cond attempt count.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data,
	output sdc_pkg::cfg_t                       cfg
);

	sdc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_limit       <= sdc_pkg::POLL_LIMIT_RST;
			cfg_q.op_cond_attempts <= sdc_pkg::ATTEMPTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdc_pkg::CFG_POLL_LIMIT: begin
					cfg_q.poll_limit <= cfg_data[sdc_pkg::POLL_LIMIT_W-1:0];
				end
				sdc_pkg::CFG_OP_COND: begin
					cfg_q.op_cond_attempts <= cfg_data[sdc_pkg::ATTEMPTS_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- design/sdc_step.sv -----
// ----------------------------------------------------------------------------
// sdc_step
// Next-state and result logic for one item of the command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_step #(
	parameter int POLL_COUNT_WIDTH = sdc_pkg::POLL_COUNT_WIDTH
) (
	input  wire sdc_pkg::item_t               item,
	input  wire sdc_pkg::seq_state_t          st,
	input  wire logic [POLL_COUNT_WIDTH-1:0]  poll_count,
	input  wire sdc_pkg::cfg_t                cfg,
	output sdc_pkg::seq_state_t               st_next,
	output logic      [POLL_COUNT_WIDTH-1:0]  poll_count_next,
	output sdc_pkg::result_t                  res
);

	localparam int CmpW = (POLL_COUNT_WIDTH > sdc_pkg::POLL_LIMIT_W) ?
		POLL_COUNT_WIDTH : sdc_pkg::POLL_LIMIT_W;
	localparam logic [POLL_COUNT_WIDTH-1:0] PollMax = '1;

	always_comb begin
		sdc_pkg::seq_state_t           ns;
		logic [POLL_COUNT_WIDTH-1:0]   npc;
		logic [POLL_COUNT_WIDTH-1:0]   n;
		sdc_pkg::result_t              r;
		logic                          busy;
		logic                          succ;
		logic                          fail;
		logic [2:0]                    fail_c;
		logic                          do_attempt;
		logic                          do_issue;
		logic [5:0]                    iss_idx;
		logic [31:0]                   iss_arg;
		logic [1:0]                    iss_kind;
		logic [3:0]                    iss_next;
		logic                          do_fin;
		logic [2:0]                    fin_st;
		logic [2:0]                    fin_cause;

		ns         = st;
		npc        = poll_count;
		n          = poll_count;
		r          = '0;
		r.seq_status = sdc_pkg::ST_BUSY;
		r.fail_cause = sdc_pkg::CAUSE_NONE;
		busy       = (st.phase >= sdc_pkg::PH_GO_IDLE) && (st.phase <= sdc_pkg::PH_XFER);
		succ       = 1'b0;
		fail       = 1'b0;
		fail_c     = sdc_pkg::CAUSE_NONE;
		do_attempt = 1'b0;
		do_issue   = 1'b0;
		iss_idx    = sdc_pkg::CMD_GO_IDLE;
		iss_arg    = '0;
		iss_kind   = sdc_pkg::KIND_NONE;
		iss_next   = sdc_pkg::PH_IDLE;
		do_fin     = 1'b0;
		fin_st     = sdc_pkg::ST_BUSY;
		fin_cause  = sdc_pkg::CAUSE_NONE;

		if (!busy) begin
			ns.phase = sdc_pkg::PH_IDLE;
		end

		if (item.op == sdc_pkg::OP_POLL) begin
			if (!busy) begin
				r.seq_status = sdc_pkg::ST_REJECT;
			end else if (item.irq_stat[sdc_pkg::BIT_COMPLETE]) begin
				r.clear_mask = sdc_pkg::CLR_COMPLETE;
				succ = 1'b1;
			end else if (item.irq_stat[sdc_pkg::BIT_TIMEOUT]) begin
				r.clear_mask = sdc_pkg::CLR_TIMEOUT;
				fail   = 1'b1;
				fail_c = sdc_pkg::CAUSE_TIMEOUT;
			end else if (item.irq_stat[sdc_pkg::BIT_CRC]) begin
				r.clear_mask = sdc_pkg::CLR_CRC;
				fail   = 1'b1;
				fail_c = sdc_pkg::CAUSE_CRC;
			end else begin
				if (poll_count != PollMax) begin
					n = poll_count + 1'b1;
				end
				npc = n;
				if ((CmpW'(n) >= CmpW'(cfg.poll_limit)) || (n == PollMax)) begin
					fail   = 1'b1;
					fail_c = sdc_pkg::CAUSE_NOINT;
				end
			end
		end else if (busy) begin
			r.seq_status = sdc_pkg::ST_REJECT;
		end else if (item.op == sdc_pkg::OP_START) begin
			ns.attempts_left = cfg.op_cond_attempts;
			do_issue = 1'b1;
			iss_idx  = sdc_pkg::CMD_GO_IDLE;
			iss_arg  = '0;
			iss_kind = sdc_pkg::KIND_NONE;
			iss_next = sdc_pkg::PH_GO_IDLE;
		end else begin
			do_issue = 1'b1;
			iss_idx  = (item.op == sdc_pkg::OP_READ) ? sdc_pkg::CMD_READ : sdc_pkg::CMD_WRITE;
			iss_arg  = st.card_is_v2 ? item.blk_num : {item.blk_num[22:0], 9'd0};
			iss_kind = sdc_pkg::KIND_SHORT;
			iss_next = sdc_pkg::PH_XFER;
		end

		if (succ) begin
			unique case (st.phase)
				sdc_pkg::PH_GO_IDLE: begin
					do_issue = 1'b1;
					iss_idx  = sdc_pkg::CMD_IF_COND;
					iss_arg  = sdc_pkg::ARG_IF_COND;
					iss_kind = sdc_pkg::KIND_SHORT;
					iss_next = sdc_pkg::PH_IF_COND;
				end
				sdc_pkg::PH_IF_COND: begin
					ns.card_is_v2 = 1'b1;
					do_attempt = 1'b1;
				end
				sdc_pkg::PH_APP: begin
					do_issue = 1'b1;
					iss_idx  = sdc_pkg::CMD_OP_COND;
					iss_arg  = sdc_pkg::ARG_OCR | (st.card_is_v2 ? sdc_pkg::ARG_HCS : 32'd0);
					iss_kind = sdc_pkg::KIND_SHORT;
					iss_next = sdc_pkg::PH_OP_COND;
				end
				sdc_pkg::PH_OP_COND: begin
					ns.op_cond_word = item.resp_word;
					if (item.resp_word[sdc_pkg::OCR_READY]) begin
						do_issue = 1'b1;
						iss_idx  = sdc_pkg::CMD_CID;
						iss_arg  = '0;
						iss_kind = sdc_pkg::KIND_LONG;
						iss_next = sdc_pkg::PH_CID;
					end else begin
						do_attempt = 1'b1;
					end
				end
				sdc_pkg::PH_CID: begin
					do_issue = 1'b1;
					iss_idx  = sdc_pkg::CMD_RCA;
					iss_arg  = '0;
					iss_kind = sdc_pkg::KIND_SHORT;
					iss_next = sdc_pkg::PH_RCA;
				end
				sdc_pkg::PH_RCA: begin
					ns.rel_card_addr = item.resp_word[31:16];
					do_issue = 1'b1;
					iss_idx  = sdc_pkg::CMD_SELECT;
					iss_arg  = {item.resp_word[31:16], 16'd0};
					iss_kind = sdc_pkg::KIND_SHORT;
					iss_next = sdc_pkg::PH_SELECT;
				end
				sdc_pkg::PH_SELECT: begin
					do_issue = 1'b1;
					iss_idx  = sdc_pkg::CMD_CSD;
					iss_arg  = {st.rel_card_addr, 16'd0};
					iss_kind = sdc_pkg::KIND_LONG;
					iss_next = sdc_pkg::PH_CSD;
				end
				sdc_pkg::PH_CSD: begin
					do_fin = 1'b1;
					fin_st = sdc_pkg::ST_INIT_OK;
				end
				default: begin
					do_fin = 1'b1;
					fin_st = sdc_pkg::ST_XFER_OK;
				end
			endcase
		end

		if (fail) begin
			unique case (st.phase)
				sdc_pkg::PH_IF_COND: begin
					ns.card_is_v2 = 1'b0;
					do_attempt = 1'b1;
				end
				sdc_pkg::PH_APP, sdc_pkg::PH_OP_COND: begin
					do_attempt = 1'b1;
				end
				sdc_pkg::PH_XFER: begin
					do_fin    = 1'b1;
					fin_st    = sdc_pkg::ST_XFER_FAIL;
					fin_cause = fail_c;
				end
				default: begin
					do_fin    = 1'b1;
					fin_st    = sdc_pkg::ST_INIT_FAIL;
					fin_cause = fail_c;
				end
			endcase
		end

		if (do_attempt) begin
			if (st.attempts_left == '0) begin
				do_fin    = 1'b1;
				fin_st    = sdc_pkg::ST_INIT_FAIL;
				fin_cause = sdc_pkg::CAUSE_EXHAUSTED;
			end else begin
				ns.attempts_left = st.attempts_left - 1'b1;
				do_issue = 1'b1;
				iss_idx  = sdc_pkg::CMD_APP;
				iss_arg  = '0;
				iss_kind = sdc_pkg::KIND_SHORT;
				iss_next = sdc_pkg::PH_APP;
			end
		end

		if (do_issue) begin
			r.issue_cmd = 1'b1;
			r.cmd_idx   = iss_idx;
			r.cmd_arg   = iss_arg;
			r.cmd_word  = {iss_idx, 1'b1, 5'd0, iss_kind};
			ns.phase    = iss_next;
			npc         = '0;
		end

		if (do_fin) begin
			r.seq_status = fin_st;
			r.fail_cause = fin_cause;
			ns.phase     = sdc_pkg::PH_IDLE;
			npc          = '0;
		end

		r.rca_out    = ns.rel_card_addr;
		r.is_v2_card = ns.card_is_v2;
		r.ocr_out    = ns.op_cond_word;

		st_next         = ns;
		poll_count_next = npc;
		res             = r;
	end

endmodule

`default_nettype wire

// ----- design/sdc_checker.sv -----
// ----------------------------------------------------------------------------
// sdc_checker
// Port-level checks of the sequencer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sd_card_init_and_block_command_sequencer_assert.svh"

module sdc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [sdc_pkg::M_TDATA_W-1:0] m_tdata
);

	logic        issue;
	logic [5:0]  cmd_idx;
	logic [31:0] cmd_arg;
	logic [13:0] cmd_word;
	logic [16:0] clear_mask;
	logic [2:0]  seq_status;
	logic [2:0]  fail_cause;
	logic        cmd_zero;
	logic        has_cause;
	logic        status_fail;
	logic        word_ok;

	assign issue      = m_tdata[0];
	assign cmd_idx    = m_tdata[6:1];
	assign cmd_arg    = m_tdata[38:7];
	assign cmd_word   = m_tdata[52:39];
	assign clear_mask = m_tdata[69:53];
	assign seq_status = m_tdata[72:70];
	assign fail_cause = m_tdata[75:73];

	assign cmd_zero    = (cmd_idx == 6'd0) && (cmd_arg == 32'd0) && (cmd_word == 14'd0);
	assign has_cause   = (fail_cause != sdc_pkg::CAUSE_NONE);
	assign status_fail = (seq_status == sdc_pkg::ST_INIT_FAIL) ||
		(seq_status == sdc_pkg::ST_XFER_FAIL);
	assign word_ok     = (cmd_word[13:8] == cmd_idx) && cmd_word[7] &&
		(seq_status == sdc_pkg::ST_BUSY);

	`SDC_ASSERT_NOW(a_idle_cmd_zero, m_tvalid && !issue, cmd_zero, "command fields without issue")
	`SDC_ASSERT_NOW(a_cause_on_fail, m_tvalid && has_cause, status_fail, "cause without failure")
	`SDC_ASSERT_NOW(a_issue_word, m_tvalid && issue, word_ok, "issued command word inconsistent")
	`SDC_ASSERT_NOW(a_clear_single, m_tvalid, $countones(clear_mask) <= 1, "clear mask not one-hot")
	`SDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed")

endmodule

bind sd_card_init_and_block_command_sequencer sdc_checker u_sdc_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// SD card sequencer testbench
// Drives start, status poll, read and write transfers into the sequencer and
// checks every result against a cycle-free model of the command walk or an
// expected entry. A directed table comes first, then random traffic shaped
// as init sequences under three idling patterns and several register settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sdc_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int RANDOM_PER_PHASE = 125;
	localparam int PRINT_CAP        = 200;
	localparam logic [POLL_COUNT_WIDTH-1:0] POLL_MAX = '1;

	typedef struct {
		bit         is_cfg;
		item_t      it;
		bit         typed;
		result_t    want;
		logic       cfg_idx;
		logic [19:0] cfg_val;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned cycles = 0;
	int unsigned errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// sequencer model state
	logic [3:0]                  seq_phase = PH_IDLE;
	logic [POLL_COUNT_WIDTH-1:0] empty_polls = '0;
	logic [7:0]                  tries_left = '0;
	logic                        card_v2 = 1'b0;
	logic [15:0]                 mdl_rca = '0;
	logic [31:0]                 mdl_ocr = '0;
	logic [19:0]                 cfg_poll_limit = POLL_LIMIT_RST;
	logic [7:0]                  cfg_attempts = ATTEMPTS_RST;
	result_t                     step_res;

	result_t owed_results[$];
	dir_row_t plan[$];

	sd_card_init_and_block_command_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		if (errors < PRINT_CAP)
			$display("ERROR cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	task automatic send_cmd(input logic [5:0] idx, input logic [31:0] arg, input logic [1:0] kind,
			input logic [3:0] nxt);
		step_res.issue_cmd = 1'b1;
		step_res.cmd_idx   = idx;
		step_res.cmd_arg   = arg;
		step_res.cmd_word  = {idx, 1'b1, 5'd0, kind};
		seq_phase   = nxt;
		empty_polls = '0;
	endtask

	task automatic end_sequence(input logic [2:0] status, input logic [2:0] cause);
		step_res.seq_status = status;
		step_res.fail_cause = cause;
		seq_phase   = PH_IDLE;
		empty_polls = '0;
	endtask

	task automatic next_attempt();
		if (tries_left == 0) begin
			end_sequence(ST_INIT_FAIL, CAUSE_EXHAUSTED);
		end else begin
			tries_left = tries_left - 1'b1;
			send_cmd(CMD_APP, '0, KIND_SHORT, PH_APP);
		end
	endtask

	task automatic poll_failed(input logic [2:0] cause);
		case (seq_phase)
			PH_IF_COND: begin
				card_v2 = 1'b0;
				next_attempt();
			end
			PH_APP, PH_OP_COND: next_attempt();
			PH_XFER: end_sequence(ST_XFER_FAIL, cause);
			default: end_sequence(ST_INIT_FAIL, cause);
		endcase
	endtask

	task automatic advance_sequencer(input item_t it, output result_t r);
		logic busy;
		logic [POLL_COUNT_WIDTH-1:0] n;
		busy = (seq_phase != PH_IDLE);
		step_res = '0;
		step_res.seq_status = ST_BUSY;
		step_res.fail_cause = CAUSE_NONE;
		if (it.op == OP_POLL) begin
			if (!busy) begin
				step_res.seq_status = ST_REJECT;
			end else if (it.irq_stat[BIT_COMPLETE]) begin
				step_res.clear_mask = CLR_COMPLETE;
				case (seq_phase)
					PH_GO_IDLE: send_cmd(CMD_IF_COND, ARG_IF_COND, KIND_SHORT, PH_IF_COND);
					PH_IF_COND: begin
						card_v2 = 1'b1;
						next_attempt();
					end
					PH_APP: send_cmd(CMD_OP_COND, ARG_OCR | (card_v2 ? ARG_HCS : 32'h0),
						KIND_SHORT, PH_OP_COND);
					PH_OP_COND: begin
						mdl_ocr = it.resp_word;
						if (it.resp_word[OCR_READY])
							send_cmd(CMD_CID, '0, KIND_LONG, PH_CID);
						else
							next_attempt();
					end
					PH_CID: send_cmd(CMD_RCA, '0, KIND_SHORT, PH_RCA);
					PH_RCA: begin
						mdl_rca = it.resp_word[31:16];
						send_cmd(CMD_SELECT, {mdl_rca, 16'h0}, KIND_SHORT, PH_SELECT);
					end
					PH_SELECT: send_cmd(CMD_CSD, {mdl_rca, 16'h0}, KIND_LONG, PH_CSD);
					PH_CSD: end_sequence(ST_INIT_OK, CAUSE_NONE);
					default: end_sequence(ST_XFER_OK, CAUSE_NONE);
				endcase
			end else if (it.irq_stat[BIT_TIMEOUT]) begin
				step_res.clear_mask = CLR_TIMEOUT;
				poll_failed(CAUSE_TIMEOUT);
			end else if (it.irq_stat[BIT_CRC]) begin
				step_res.clear_mask = CLR_CRC;
				poll_failed(CAUSE_CRC);
			end else begin
				n = empty_polls;
				if (n != POLL_MAX)
					n = n + 1'b1;
				empty_polls = n;
				if (n >= cfg_poll_limit || n == POLL_MAX)
					poll_failed(CAUSE_NOINT);
			end
		end else if (busy) begin
			step_res.seq_status = ST_REJECT;
		end else if (it.op == OP_START) begin
			tries_left = cfg_attempts;
			send_cmd(CMD_GO_IDLE, '0, KIND_NONE, PH_GO_IDLE);
		end else begin
			send_cmd(it.op == OP_READ ? CMD_READ : CMD_WRITE,
				card_v2 ? it.blk_num : it.blk_num << 9, KIND_SHORT, PH_XFER);
		end
		step_res.rca_out    = mdl_rca;
		step_res.is_v2_card = card_v2;
		step_res.ocr_out    = mdl_ocr;
		r = step_res;
	endtask

	// bias toward well-formed init walks: mostly polls while a command is out
	function automatic item_t random_item();
		item_t it;
		int pick;
		it.irq_stat  = $urandom;
		it.resp_word = $urandom;
		it.blk_num   = $urandom;
		it.op        = 2'($urandom);
		pick = $urandom_range(99);
		if (seq_phase == PH_IDLE) begin
			if (pick < 40)
				it.op = OP_START;
			else if (pick < 85)
				it.op = $urandom_range(1) ? OP_READ : OP_WRITE;
		end else if (pick < 88) begin
			it.op = OP_POLL;
		end
		if (it.op == OP_POLL) begin
			pick = $urandom_range(99);
			it.irq_stat[BIT_COMPLETE] = (pick < 70);
			if (pick >= 70) begin
				it.irq_stat[BIT_TIMEOUT] = (pick < 80);
				if (pick >= 80)
					it.irq_stat[BIT_CRC] = (pick < 90);
			end
			if (seq_phase == PH_OP_COND)
				it.resp_word[OCR_READY] = ($urandom_range(99) < 65);
		end
		return it;
	endfunction

	function automatic dir_row_t row(input logic [1:0] op, input logic [31:0] st,
			input logic [31:0] resp, input logic [31:0] blk);
		dir_row_t d;
		d.is_cfg = 1'b0;
		d.it.op = op;
		d.it.irq_stat = st;
		d.it.resp_word = resp;
		d.it.blk_num = blk;
		d.typed = 1'b0;
		d.want = '0;
		d.cfg_idx = 1'b0;
		d.cfg_val = '0;
		return d;
	endfunction

	function automatic dir_row_t row_cfg(input logic idx, input logic [19:0] val);
		dir_row_t d;
		d = row(OP_POLL, '0, '0, '0);
		d.is_cfg = 1'b1;
		d.cfg_idx = idx;
		d.cfg_val = val;
		return d;
	endfunction

	function automatic dir_row_t checked(input dir_row_t d, input result_t want);
		d.typed = 1'b1;
		d.want = want;
		return d;
	endfunction

	function automatic result_t outcome(input logic [2:0] status, input logic [2:0] cause,
			input logic [16:0] clear);
		result_t r;
		r = '0;
		r.seq_status = status;
		r.fail_cause = cause;
		r.clear_mask = clear;
		return r;
	endfunction

	task automatic send_item(input item_t it, output result_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {it.blk_num, it.resp_word, it.irq_stat};
		do @(posedge clk); while (!s_tready);
		advance_sequencer(it, r);
	endtask

	task automatic write_register(input logic idx, input logic [19:0] val);
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POLL_LIMIT)
			cfg_poll_limit = val;
		else
			cfg_attempts = val[7:0];
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[$bits(result_t)-1:0]);
			if (owed_results.size() == 0) begin
				report_error("result transfer with nothing expected");
			end else begin
				want = owed_results.pop_front();
				check_field("issue_cmd", got.issue_cmd, want.issue_cmd);
				check_field("cmd_idx", got.cmd_idx, want.cmd_idx);
				check_field("cmd_arg", got.cmd_arg, want.cmd_arg);
				check_field("cmd_word", got.cmd_word, want.cmd_word);
				check_field("clear_mask", got.clear_mask, want.clear_mask);
				check_field("seq_status", got.seq_status, want.seq_status);
				check_field("fail_cause", got.fail_cause, want.fail_cause);
				check_field("rca_out", got.rca_out, want.rca_out);
				check_field("is_v2_card", got.is_v2_card, want.is_v2_card);
				check_field("ocr_out", got.ocr_out, want.ocr_out);
			end
		end
	end

	initial begin
		result_t r;
		result_t rd_first;
		logic [19:0] val;

		rd_first = outcome(ST_BUSY, CAUSE_NONE, '0);
		rd_first.issue_cmd = 1'b1;
		rd_first.cmd_idx   = CMD_READ;
		rd_first.cmd_arg   = 32'hFFFF_FE00;
		rd_first.cmd_word  = {CMD_READ, 1'b1, 5'd0, KIND_SHORT};

		// transfers before init, busy and idle rejects, status priority
		plan.push_back(checked(row(OP_POLL, '0, '0, '0), outcome(ST_REJECT, CAUSE_NONE, '0)));
		plan.push_back(checked(row(OP_READ, $urandom, $urandom, '1), rd_first));
		plan.push_back(checked(row(OP_START, '0, '0, '0), outcome(ST_REJECT, CAUSE_NONE, '0)));
		plan.push_back(checked(row(OP_POLL, '0, '1, '1), outcome(ST_BUSY, CAUSE_NONE, '0)));
		plan.push_back(checked(row(OP_POLL, '1, '1, '0),
			outcome(ST_XFER_OK, CAUSE_NONE, CLR_COMPLETE)));
		plan.push_back(row(OP_WRITE, '0, '0, 32'd1));
		plan.push_back(checked(row(OP_POLL, 32'h0001_8000, '0, '0),
			outcome(ST_XFER_FAIL, CAUSE_TIMEOUT, CLR_TIMEOUT)));
		// v1 walk: CMD8 timeout, OCR not ready, CRC on CMD55, then ready
		plan.push_back(row(OP_START, '0, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, 32'h0001_0000, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, 32'h00FF_8000, '0));
		plan.push_back(row(OP_POLL, 32'h0000_8000, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, 32'h80FF_8000, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, 32'hFFFF_0000, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		// poll limit of one, no attempts
		plan.push_back(row_cfg(CFG_POLL_LIMIT, 20'd1));
		plan.push_back(row_cfg(CFG_OP_COND, 20'd0));
		plan.push_back(row(OP_START, '0, '0, '0));
		plan.push_back(row(OP_POLL, 32'hFFFE_7FFE, '0, '0));
		plan.push_back(row(OP_START, '0, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, '0, '0, '0));
		// largest settings, v2 card with HCS
		plan.push_back(row_cfg(CFG_POLL_LIMIT, 20'hFFFFF));
		plan.push_back(row_cfg(CFG_OP_COND, 20'h000FF));
		plan.push_back(row(OP_START, '0, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, 32'h1, '0, '0));
		plan.push_back(row(OP_POLL, '0, '0, '0));
		plan.push_back(row(OP_POLL, 32'h0001_0000, '0, '0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_register(plan[i].cfg_idx, plan[i].cfg_val);
			end else begin
				send_item(plan[i].it, r);
				owed_results.push_back(plan[i].typed ? plan[i].want : r);
			end
		end

		for (int m = 0; m < 3; m++) begin
			case (m)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 66;
					write_register(CFG_POLL_LIMIT, 20'($urandom_range(1, 3)));
					val = 20'($urandom);
					val[7:0] = 8'($urandom_range(2, 5));
					write_register(CFG_OP_COND, val);
				end
				1: begin
					send_idle_pct = 66;
					recv_idle_pct = 34;
					write_register(CFG_POLL_LIMIT, 20'($urandom_range(0, 2)));
					val = 20'($urandom);
					val[7:0] = 8'($urandom_range(0, 2));
					write_register(CFG_OP_COND, val);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					write_register(CFG_POLL_LIMIT, 20'($urandom_range(2, 8)));
					write_register(CFG_OP_COND, 20'h000FF);
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				send_item(random_item(), r);
				owed_results.push_back(r);
			end
		end

		// drain
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
